[rtl/ssc_pkg.sv]
package ssc_pkg;

    localparam int DW       = 32;
    localparam int CW       = 48;
    localparam int OUT_FRAC = 24;
    localparam int XW       = 38;
    localparam int NSTEP    = 5;

    localparam logic [1:0] KIND_LINEAR = 2'd0;
    localparam logic [1:0] KIND_CUBIC  = 2'd1;

    localparam logic signed [CW-1:0] COEF_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] COEF_MIN = {1'b1, {(CW-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_SAT  = 2'd2
    } t_status;

    typedef struct packed {
        logic        [1:0]    profile_kind;
        logic        [2:0]    axis;
        logic signed [DW-1:0] start_pos;
        logic signed [DW-1:0] end_pos;
        logic signed [DW-1:0] start_vel;
        logic signed [DW-1:0] end_vel;
        logic signed [DW-1:0] start_acc;
        logic signed [DW-1:0] end_acc;
        logic        [DW-1:0] duration;
    } t_seg;

    typedef struct packed {
        logic        [2:0]    axis_out;
        logic signed [CW-1:0] coef0;
        logic signed [CW-1:0] coef1;
        logic signed [CW-1:0] coef2;
        logic signed [CW-1:0] coef3;
        logic signed [CW-1:0] coef4;
        logic signed [CW-1:0] coef5;
        logic        [1:0]    status;
    } t_coef;

    // per-coefficient work travelling down one division chain
    typedef struct packed {
        logic                       exact;
        logic                       e;
        logic [2:0]                 k;
        logic [DW-1:0]              d;
        logic [NSTEP-1:0][XW-1:0]   terms;
    } t_cpay;

    typedef struct packed {
        logic [2:0]    axis;
        logic [1:0]    kind;
        logic          zero;
        logic [DW-1:0] p0;
        logic [DW-1:0] v0;
        logic [DW-1:0] a0;
    } t_side;

endpackage

[rtl/ssc_if.sv]
interface ssc_seg_if import ssc_pkg::*; ();
    logic valid;
    logic ready;
    t_seg data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ssc_coef_if import ssc_pkg::*; ();
    logic  valid;
    logic  ready;
    t_coef data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/ssc_fdiv.sv]
module ssc_fdiv import ssc_pkg::*; #(
    parameter int W  = 129,
    parameter int PW = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic signed [W-1:0] i_num,
    input  logic [DW-1:0]       i_den,
    input  logic [PW-1:0]       i_pay,
    output logic                o_valid,
    output logic signed [W-1:0] o_quo,
    output logic                o_exact,
    output logic [PW-1:0]       o_pay
);

    logic          r_v    [W];
    logic [W-1:0]  r_word [W];
    logic [DW-1:0] r_rem  [W];
    logic [DW-1:0] r_den  [W];
    logic          r_neg  [W];
    logic [PW-1:0] r_pay  [W];

    // one quotient bit per stage, floor division via one's complement
    for (genvar s = 0; s < W; s++) begin : g_bit
        logic          s_v;
        logic          s_neg;
        logic [W-1:0]  s_word;
        logic [W-1:0]  n_word;
        logic [DW-1:0] s_rem;
        logic [DW-1:0] s_den;
        logic [DW-1:0] n_rem;
        logic [PW-1:0] s_pay;
        logic [DW:0]   t;

        if (s == 0) begin : g_head
            assign s_v    = i_valid;
            assign s_neg  = i_num[W-1];
            assign s_word = i_num ^ {W{i_num[W-1]}};
            assign s_rem  = '0;
            assign s_den  = i_den;
            assign s_pay  = i_pay;
        end else begin : g_tail
            assign s_v    = r_v[s-1];
            assign s_neg  = r_neg[s-1];
            assign s_word = r_word[s-1];
            assign s_rem  = r_rem[s-1];
            assign s_den  = r_den[s-1];
            assign s_pay  = r_pay[s-1];
        end

        assign t = {s_rem, s_word[W-1-s]};

        always_comb begin
            n_word = s_word;
            if (t >= {1'b0, s_den}) begin
                n_rem            = DW'(t - {1'b0, s_den});
                n_word[W-1-s]    = 1'b1;
            end else begin
                n_rem            = t[DW-1:0];
                n_word[W-1-s]    = 1'b0;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= s_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_word[s] <= n_word;
                r_rem[s]  <= n_rem;
                r_den[s]  <= s_den;
                r_neg[s]  <= s_neg;
                r_pay[s]  <= s_pay;
            end
        end
    end

    assign o_valid = r_v[W-1];
    assign o_quo   = r_word[W-1] ^ {W{r_neg[W-1]}};
    assign o_exact = r_neg[W-1] ? (({1'b0, r_rem[W-1]} + (DW+1)'(1)) == {1'b0, r_den[W-1]})
                                : (r_rem[W-1] == '0);
    assign o_pay   = r_pay[W-1];

endmodule

[rtl/ssc_chain.sv]
module ssc_chain import ssc_pkg::*; #(
    parameter int W  = 129,
    parameter int FB = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  t_cpay               i_pay,
    output logic                o_valid,
    output logic signed [W-1:0] o_g,
    output logic                o_exact
);

    localparam int PW = $bits(t_cpay);

    logic                v   [NSTEP];
    logic signed [W-1:0] q   [NSTEP];
    logic                ex  [NSTEP];
    logic [PW-1:0]       pay [NSTEP];
    t_cpay               last;

    // horner over powers of the duration: add term, divide, repeat
    for (genvar i = 0; i < NSTEP; i++) begin : g_step
        localparam int SH = (NSTEP - 1 - i) * FB + OUT_FRAC;

        t_cpay               cur;
        logic signed [W-1:0] base;
        logic signed [W-1:0] tx;
        logic signed [W-1:0] acc;
        logic [DW-1:0]       den;
        logic                vin;

        if (i == 0) begin : g_head
            assign cur  = i_pay;
            assign base = '0;
            assign vin  = i_valid;
        end else begin : g_tail
            always_comb begin
                cur       = t_cpay'(pay[i-1]);
                cur.exact = cur.exact & ex[i-1];
            end
            assign base = q[i-1];
            assign vin  = v[i-1];
        end

        assign tx  = W'($signed(cur.terms[i]));
        assign acc = base + (cur.e ? (tx <<< (SH + 1)) : (tx <<< SH));
        // leading steps of a lower power divide by one
        assign den = (cur.k >= 3'(NSTEP - i)) ? cur.d : DW'(1);

        ssc_fdiv #(.W(W), .PW(PW)) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (vin),
            .i_num   (acc),
            .i_den   (den),
            .i_pay   (cur),
            .o_valid (v[i]),
            .o_quo   (q[i]),
            .o_exact (ex[i]),
            .o_pay   (pay[i])
        );
    end

    assign last    = t_cpay'(pay[NSTEP-1]);
    assign o_valid = v[NSTEP-1];
    assign o_g     = q[NSTEP-1];
    assign o_exact = last.exact & ex[NSTEP-1];

endmodule

[rtl/ssc_round.sv]
module ssc_round import ssc_pkg::*; #(
    parameter int W = 129
) (
    input  logic signed [W-1:0]  i_g,
    input  logic                 i_exact,
    output logic signed [CW-1:0] o_coef,
    output logic                 o_sat
);

    logic signed [W:0]  g1;
    logic signed [W:0]  q;
    logic [W-CW+1:0]    upper;

    // i_g is floor of twice the value; round half away from zero
    assign g1    = (W+1)'(i_g) + ((i_g[W-1] && i_exact) ? (W+1)'(0) : (W+1)'(1));
    assign q     = g1 >>> 1;
    assign upper = q[W:CW-1];
    assign o_sat = !((&upper) || !(|upper));
    assign o_coef = o_sat ? (q[W] ? COEF_MIN : COEF_MAX) : q[CW-1:0];

endmodule

[rtl/spline_segment_coefficients.sv]
// Polynomial trajectory coefficients for one axis segment per transfer.
// Input channel i_seg carries the profile kind, axis, start and end position,
// velocity and acceleration, and the duration, all Q(FRAC_BITS). Output channel
// o_coef returns the axis, coefficients c0..c5 in signed Q24.24 and a status:
// ok, zero duration (all coefficients zero) or saturated.
// Each divided coefficient comes from a chain of five floor dividers (by the
// duration or by one), one quotient bit per stage over W = 4*FRAC_BITS+65 bits;
// a segment passes through one input register, the divider chains, the
// rounding and one output register. Throughput is one segment per cycle
// unless the receiver stalls; three chains run side by side.
// Reset clears all valid bits; the data registers are not reset.
// When the receiver stalls, the whole pipeline holds and i_seg.ready drops
// while the output register stays full; nothing is dropped or repeated.
module spline_segment_coefficients import ssc_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ssc_seg_if.sink     i_seg,
    ssc_coef_if.source  o_coef
);

    localparam int W   = 4 * FRAC_BITS + 65;
    localparam int LAT = NSTEP * W;
    localparam int SH  = OUT_FRAC - FRAC_BITS;

    logic en;

    t_seg                 s;
    logic signed [XW-1:0] p0, p1, v0, v1, a0, a1, dp;
    t_cpay                n_pa, n_pb, n_pc;
    t_side                n_ps;
    logic                 r_pv;
    t_cpay                r_pa, r_pb, r_pc;
    t_side                r_ps;
    t_side                r_sb [LAT];
    t_side                sb;

    logic                 va, vb, vc;
    logic signed [W-1:0]  ga, gb, gc;
    logic                 xa, xb, xc;
    logic signed [CW-1:0] ca, cb, cc;
    logic                 sa, sbt, sc;

    logic signed [CW-1:0] c0v, v0v, a0s, a0h;
    t_coef                n_out;
    t_coef                r_out;
    logic                 r_ov;

    assign en          = !r_ov || o_coef.ready;
    assign i_seg.ready = en;

    assign s  = i_seg.data;
    assign p0 = XW'($signed(s.start_pos));
    assign p1 = XW'($signed(s.end_pos));
    assign v0 = XW'($signed(s.start_vel));
    assign v1 = XW'($signed(s.end_vel));
    assign a0 = XW'($signed(s.start_acc));
    assign a1 = XW'($signed(s.end_acc));
    assign dp = p1 - p0;

    always_comb begin
        n_pa       = '0;
        n_pa.exact = 1'b1;
        n_pa.d     = s.duration;
        n_pa.e     = 1'b1;
        n_pa.k     = 3'd1;
        n_pb       = n_pa;
        n_pc       = n_pa;
        case (s.profile_kind)
            KIND_LINEAR: begin
                n_pa.terms[4] = dp;
            end
            KIND_CUBIC: begin
                n_pa.k        = 3'd2;
                n_pa.terms[3] = XW'(3) * dp;
                n_pa.terms[4] = -((v0 <<< 1) + v1);
                n_pb.k        = 3'd3;
                n_pb.terms[2] = -(dp <<< 1);
                n_pb.terms[3] = v0 + v1;
            end
            default: begin
                n_pa.e        = 1'b0;
                n_pa.k        = 3'd3;
                n_pa.terms[2] = XW'(20) * dp;
                n_pa.terms[3] = -(XW'(12) * v0 + (v1 <<< 3));
                n_pa.terms[4] = -(XW'(3) * a0 - a1);
                n_pb.e        = 1'b0;
                n_pb.k        = 3'd4;
                n_pb.terms[1] = -(XW'(30) * dp);
                n_pb.terms[2] = (v0 <<< 4) + XW'(14) * v1;
                n_pb.terms[3] = XW'(3) * a0 - (a1 <<< 1);
                n_pc.e        = 1'b0;
                n_pc.k        = 3'd5;
                n_pc.terms[0] = XW'(12) * dp;
                n_pc.terms[1] = -(XW'(6) * (v0 + v1));
                n_pc.terms[2] = -(a0 - a1);
            end
        endcase
    end

    always_comb begin
        n_ps.axis = s.axis;
        n_ps.kind = s.profile_kind;
        n_ps.zero = (s.duration == '0);
        n_ps.p0   = s.start_pos;
        n_ps.v0   = s.start_vel;
        n_ps.a0   = s.start_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (en) begin
            r_pv <= i_seg.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pa <= n_pa;
            r_pb <= n_pb;
            r_pc <= n_pc;
            r_ps <= n_ps;
        end
    end

    // sideband fields ride alongside the divider chains
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb[0] <= r_ps;
            for (int j = 1; j < LAT; j++) begin
                r_sb[j] <= r_sb[j-1];
            end
        end
    end

    assign sb = r_sb[LAT-1];

    ssc_chain #(.W(W), .FB(FRAC_BITS)) u_chain_a (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_valid (r_pv),
        .i_pay (r_pa), .o_valid (va), .o_g (ga), .o_exact (xa)
    );

    ssc_chain #(.W(W), .FB(FRAC_BITS)) u_chain_b (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_valid (r_pv),
        .i_pay (r_pb), .o_valid (vb), .o_g (gb), .o_exact (xb)
    );

    ssc_chain #(.W(W), .FB(FRAC_BITS)) u_chain_c (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_valid (r_pv),
        .i_pay (r_pc), .o_valid (vc), .o_g (gc), .o_exact (xc)
    );

    ssc_round #(.W(W)) u_round_a (.i_g (ga), .i_exact (xa), .o_coef (ca), .o_sat (sa));
    ssc_round #(.W(W)) u_round_b (.i_g (gb), .i_exact (xb), .o_coef (cb), .o_sat (sbt));
    ssc_round #(.W(W)) u_round_c (.i_g (gc), .i_exact (xc), .o_coef (cc), .o_sat (sc));

    assign c0v = CW'($signed(sb.p0)) <<< SH;
    assign v0v = CW'($signed(sb.v0)) <<< SH;
    assign a0s = CW'($signed(sb.a0)) <<< SH;
    assign a0h = a0s[CW-1] ? (a0s >>> 1) : ((a0s + CW'(1)) >>> 1);

    always_comb begin
        logic sat;
        n_out          = '0;
        n_out.axis_out = sb.axis;
        n_out.coef0    = c0v;
        case (sb.kind)
            KIND_LINEAR: begin
                n_out.coef1 = ca;
                sat         = sa;
            end
            KIND_CUBIC: begin
                n_out.coef1 = v0v;
                n_out.coef2 = ca;
                n_out.coef3 = cb;
                sat         = sa || sbt;
            end
            default: begin
                n_out.coef1 = v0v;
                n_out.coef2 = a0h;
                n_out.coef3 = ca;
                n_out.coef4 = cb;
                n_out.coef5 = cc;
                sat         = sa || sbt || sc;
            end
        endcase
        n_out.status = sat ? ST_SAT : ST_OK;
        if (sb.zero) begin
            n_out          = '0;
            n_out.axis_out = sb.axis;
            n_out.status   = ST_ZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_coef.valid = r_ov;
    assign o_coef.data  = r_out;

    a_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (va == vb) && (vb == vc))
        else $error("divider chains out of step");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_seg.valid && i_seg.ready) |=> r_pv)
        else $error("accepted segment not captured");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_coef.valid && o_coef.data.status == ST_ZERO) |->
        (o_coef.data.coef0 == '0 && o_coef.data.coef1 == '0 && o_coef.data.coef2 == '0 &&
         o_coef.data.coef3 == '0 && o_coef.data.coef4 == '0 && o_coef.data.coef5 == '0))
        else $error("zero duration with nonzero coefficients");

    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_coef.valid && o_coef.data.status == ST_SAT) |->
        (o_coef.data.coef1 == COEF_MAX || o_coef.data.coef1 == COEF_MIN ||
         o_coef.data.coef2 == COEF_MAX || o_coef.data.coef2 == COEF_MIN ||
         o_coef.data.coef3 == COEF_MAX || o_coef.data.coef3 == COEF_MIN ||
         o_coef.data.coef4 == COEF_MAX || o_coef.data.coef4 == COEF_MIN ||
         o_coef.data.coef5 == COEF_MAX || o_coef.data.coef5 == COEF_MIN))
        else $error("saturation flagged without a clamped coefficient");

endmodule
